/* sv/cpt_pkg.sv */
package cpt_pkg;

    // Default sizes
    localparam int KEY_LIMIT_DEF   = 64;
    localparam int INDEX_CHARS_DEF = 32;

    // Results per input item, and the queue between the front and back parts
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    localparam logic [2:0] TK_CHAR   = 3'd0;
    localparam logic [2:0] TK_KEYEND = 3'd1;
    localparam logic [2:0] TK_INDEX  = 3'd2;
    localparam logic [2:0] TK_WILD   = 3'd3;
    localparam logic [2:0] TK_END    = 3'd4;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // Index magnitude limit, 2^31
    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic [7:0]         key_char;
        logic signed [31:0] index_value;
        logic               status;
        logic [7:0]         segment_count;
        logic               last_of_run;
    } out_item_t;

    // One queue entry: the results of one input item
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        out_item_t [MAX_RESULTS-1:0]     slot;
    } cmd_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_key_char(input logic [7:0] c);
        return (c == CH_UNDER) || (c == CH_MINUS) || is_digit(c) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
               ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic out_item_t mk_item(input logic [2:0]  kind,
                                          input logic [7:0]  kc,
                                          input logic [31:0] idx,
                                          input logic        st,
                                          input logic [7:0]  seg);
        out_item_t r;
        r.token_kind    = kind;
        r.key_char      = kc;
        r.index_value   = $signed(idx);
        r.status        = st;
        r.segment_count = seg;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

endpackage

/* sv/cpt_front.sv */
module cpt_front
    import cpt_pkg::*;
#(
    parameter int KEY_LIMIT   = KEY_LIMIT_DEF,
    parameter int INDEX_CHARS = INDEX_CHARS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     char_valid,
    output logic     char_stall,
    input  in_item_t char_item,
    input  logic     q_full,
    output logic     push,
    output cmd_t     push_cmd
);

    localparam int KL_W = $clog2(KEY_LIMIT);
    localparam int IC_W = $clog2(INDEX_CHARS);
    localparam logic [KL_W-1:0] KL_MAX = KL_W'(KEY_LIMIT - 1);
    localparam logic [IC_W-1:0] IC_MAX = IC_W'(INDEX_CHARS - 1);

    typedef enum logic [2:0] {
        S_START,
        S_KEY,
        S_DOT,
        S_BRACKET,
        S_AFTER,
        S_FAIL
    } state_t;

    state_t          st_reg, st_next;
    logic [KL_W-1:0] kl_reg, kl_next;
    logic [31:0]     acc_reg, acc_next;
    logic            neg_reg, neg_next;
    logic [IC_W-1:0] ic_reg, ic_next;
    logic            wild_reg, wild_next;
    logic            sp_reg, sp_next;
    logic            err_reg, err_next;
    logic [7:0]      seg_reg, seg_next;

    logic            accept;
    logic [7:0]      c;
    logic [35:0]     prod;
    logic [31:0]     idx_val;
    logic [CNT_W-1:0] n;
    out_item_t       slots [0:MAX_RESULTS];

    assign char_stall = q_full;
    assign accept     = char_valid && !q_full;
    assign c          = char_item.ch;

    // accum * 10 + digit
    assign prod    = (36'(acc_reg) << 3) + (36'(acc_reg) << 1) + 36'(c[3:0]);
    assign idx_val = neg_reg ? (32'd0 - acc_reg) : (acc_reg[31] ? POS_MAX : acc_reg);

    always_comb
    begin
        st_next   = st_reg;
        kl_next   = kl_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        ic_next   = ic_reg;
        wild_next = wild_reg;
        sp_next   = sp_reg;
        err_next  = err_reg;
        seg_next  = seg_reg;
        n         = '0;
        for (int i = 0; i <= MAX_RESULTS; i++)
        begin
            slots[i] = '0;
        end

        if (c != CH_NUL && !err_reg)
        begin
            case (st_reg)
                S_START, S_DOT:
                begin
                    if (c == CH_DOT)
                    begin
                        st_next = S_DOT;
                    end
                    else if (c == CH_LBRACK && st_reg == S_START)
                    begin
                        acc_next  = '0;
                        neg_next  = 1'b0;
                        ic_next   = '0;
                        wild_next = 1'b0;
                        sp_next   = 1'b0;
                        st_next   = S_BRACKET;
                    end
                    else if (is_key_char(c))
                    begin
                        sp_next = 1'b0;
                        kl_next = KL_W'(1);
                        slots[n] = mk_item(TK_CHAR, c, '0, 1'b0, seg_reg);
                        n = n + 1'b1;
                        st_next = S_KEY;
                    end
                    else if (!is_blank(c))
                    begin
                        st_next  = S_FAIL;
                        err_next = 1'b1;
                    end
                end
                S_KEY:
                begin
                    if (c == CH_DOT || c == CH_LBRACK)
                    begin
                        if (seg_next != 8'hFF)
                            seg_next = seg_next + 8'd1;
                        slots[n] = mk_item(TK_KEYEND, '0, '0, 1'b0, seg_next);
                        n = n + 1'b1;
                        kl_next = '0;
                        sp_next = 1'b0;
                        if (c == CH_DOT)
                        begin
                            st_next = S_DOT;
                        end
                        else
                        begin
                            acc_next  = '0;
                            neg_next  = 1'b0;
                            ic_next   = '0;
                            wild_next = 1'b0;
                            st_next   = S_BRACKET;
                        end
                    end
                    else if (is_key_char(c))
                    begin
                        if (sp_reg)
                        begin
                            st_next  = S_FAIL;
                            err_next = 1'b1;
                        end
                        else if (kl_reg < KL_MAX)
                        begin
                            kl_next = kl_reg + 1'b1;
                            slots[n] = mk_item(TK_CHAR, c, '0, 1'b0, seg_reg);
                            n = n + 1'b1;
                        end
                    end
                    else if (is_blank(c))
                    begin
                        if (kl_reg != '0)
                            sp_next = 1'b1;
                    end
                    else
                    begin
                        st_next  = S_FAIL;
                        err_next = 1'b1;
                    end
                end
                S_BRACKET:
                begin
                    if (is_digit(c))
                    begin
                        if (sp_reg)
                        begin
                            st_next  = S_FAIL;
                            err_next = 1'b1;
                        end
                        else if (ic_reg < IC_MAX)
                        begin
                            acc_next = (prod > 36'(MAG_LIMIT)) ? MAG_LIMIT : prod[31:0];
                            ic_next  = ic_reg + 1'b1;
                        end
                    end
                    else if (c == CH_RBRACK)
                    begin
                        // wildcard mixed with digits or a sign
                        if (wild_reg && ic_reg != '0)
                        begin
                            st_next  = S_FAIL;
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (seg_next != 8'hFF)
                                seg_next = seg_next + 8'd1;
                            if (wild_reg)
                                slots[n] = mk_item(TK_WILD, '0, '0, 1'b0, seg_next);
                            else
                                slots[n] = mk_item(TK_INDEX, '0, idx_val, 1'b0, seg_next);
                            n = n + 1'b1;
                            acc_next  = '0;
                            neg_next  = 1'b0;
                            ic_next   = '0;
                            wild_next = 1'b0;
                            sp_next   = 1'b0;
                            st_next   = S_AFTER;
                        end
                    end
                    else if (c == CH_STAR)
                    begin
                        wild_next = 1'b1;
                    end
                    else if (is_blank(c))
                    begin
                        if (ic_reg != '0)
                            sp_next = 1'b1;
                    end
                    else if ((c == CH_MINUS || c == CH_PLUS) && ic_reg == '0)
                    begin
                        neg_next = (c == CH_MINUS);
                        ic_next  = IC_W'(1);
                    end
                    else
                    begin
                        st_next  = S_FAIL;
                        err_next = 1'b1;
                    end
                end
                S_AFTER:
                begin
                    if (c == CH_DOT)
                    begin
                        st_next = S_DOT;
                    end
                    else if (!is_blank(c))
                    begin
                        st_next  = S_FAIL;
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (char_item.last)
        begin
            if (!err_next)
            begin
                if (st_next == S_KEY)
                begin
                    if (seg_next != 8'hFF)
                        seg_next = seg_next + 8'd1;
                    slots[n] = mk_item(TK_KEYEND, '0, '0, 1'b0, seg_next);
                    n = n + 1'b1;
                end
                else if (st_next == S_BRACKET)
                begin
                    // unclosed bracket
                    err_next = 1'b1;
                end
            end
            slots[n] = mk_item(TK_END, '0, '0, err_next, seg_next);
            n = n + 1'b1;
            st_next   = S_START;
            kl_next   = '0;
            acc_next  = '0;
            neg_next  = 1'b0;
            ic_next   = '0;
            wild_next = 1'b0;
            sp_next   = 1'b0;
            err_next  = 1'b0;
            seg_next  = '0;
        end

        push_cmd.cnt = n;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            push_cmd.slot[i]             = slots[i];
            push_cmd.slot[i].last_of_run = (CNT_W'(i) == n - 1'b1);
        end
    end

    assign push = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_START;
            kl_reg   <= '0;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            ic_reg   <= '0;
            wild_reg <= 1'b0;
            sp_reg   <= 1'b0;
            err_reg  <= 1'b0;
            seg_reg  <= '0;
        end
        else if (accept)
        begin
            st_reg   <= st_next;
            kl_reg   <= kl_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            ic_reg   <= ic_next;
            wild_reg <= wild_next;
            sp_reg   <= sp_next;
            err_reg  <= err_next;
            seg_reg  <= seg_next;
        end
    end

    a_fail_err: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_FAIL) |-> err_reg)
        else $error("fail state without error flag");

    a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= MAG_LIMIT)
        else $error("index magnitude past saturation limit");

endmodule

/* sv/cpt_queue.sv */
module cpt_queue
    import cpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic not_empty
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !not_empty))
        else $error("read from empty queue");

endmodule

/* sv/cpt_back.sv */
module cpt_back
    import cpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head,
    output logic      pop,
    output logic      token_valid,
    input  logic      token_stall,
    output out_item_t token_item
);

    logic [CNT_W-1:0] sub_reg, sub_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             load;
    logic             at_end;

    assign load   = head_valid && (!out_valid_reg || !token_stall);
    assign at_end = (sub_reg == head.cnt - 1'b1);
    assign pop    = load && at_end;

    always_comb
    begin
        sub_next       = sub_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && token_stall;
        if (load)
        begin
            out_next       = head.slot[sub_reg];
            out_valid_next = 1'b1;
            sub_next       = at_end ? '0 : sub_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_item  = out_reg;

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (sub_reg < head.cnt))
        else $error("slot index past entry count");

    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.token_kind == TK_END) |-> out_reg.last_of_run)
        else $error("path end not marked last of run");

endmodule

/* sv/config_path_tokenizer.sv */
// Configuration path tokenizer.
// Input channel (char_valid / char_stall / char_item): one path byte per item,
// char_item.last marks the final item of a path; a zero byte with last set is
// a bare end marker. Output channel (token_valid / token_stall / token_item):
// key characters, key ends, numeric or wildcard indexes and one path-end token
// carrying status and segment count. An item is moved on a rising edge with
// valid high and stall low.
// Each accepted item's results enter the queue on the accepting edge; the
// output register then loads them from the queue head when it is free.
// Throughput: one input item per cycle while each item yields at most one
// result and token_stall stays low; an item yielding k results (k up to 3)
// gives them out one per output token. The back end's single output register
// sets that rate; a 4-entry queue between parser and output absorbs bursts,
// and char_stall rises only when that queue is full.
// Reset clears the parser to its start state and empties the queue and the
// output register. While token_stall is high the current token is held and
// the queue fills; input keeps flowing until the queue is full.
module config_path_tokenizer
    import cpt_pkg::*;
#(
    parameter int KEY_LIMIT   = KEY_LIMIT_DEF,
    parameter int INDEX_CHARS = INDEX_CHARS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  in_item_t  char_item,
    output logic      token_valid,
    input  logic      token_stall,
    output out_item_t token_item
);

    // front -> queue
    logic q_full;
    logic push;
    cmd_t push_cmd;

    // queue -> back
    logic q_not_empty;
    logic pop;
    cmd_t head;

    cpt_front #(
        .KEY_LIMIT   (KEY_LIMIT),
        .INDEX_CHARS (INDEX_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    cpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (push_cmd),
        .full      (q_full),
        .rd_en     (pop),
        .rd_data   (head),
        .not_empty (q_not_empty)
    );

    cpt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_not_empty),
        .head        (head),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

endmodule

/* sim/token_checker.sv */
`timescale 1ns / 1ps

module token_checker
    import cpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    input  logic      char_stall,
    input  in_item_t  char_item,
    input  logic      token_valid,
    input  logic      token_stall,
    input  out_item_t token_item,
    output int        fail_count,
    output int        pending
);

    localparam int KEY_KEEP = KEY_LIMIT_DEF - 1;
    localparam int IDX_KEEP = INDEX_CHARS_DEF - 1;

    typedef enum logic [2:0] {
        PS_START,
        PS_KEY,
        PS_DOT,
        PS_BRACKET,
        PS_AFTER,
        PS_FAIL
    } parse_t;

    parse_t      pstate;
    int          key_len;
    logic [31:0] idx_mag;
    logic        idx_neg;
    int          idx_len;
    logic        idx_star;
    logic        gap_seen;
    logic        bad_path;
    logic [7:0]  seg_cnt;

    out_item_t   expected_tokens[$];
    out_item_t   item_tokens[$];
    out_item_t   oldest;

    function automatic logic decimal_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic name_byte(input logic [7:0] c);
        if (c == CH_UNDER || c == CH_MINUS || decimal_byte(c))
            return 1'b1;
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic string token_text(input out_item_t t);
        return $sformatf("kind=%0d char=%02h index=%0d status=%0d segs=%0d last=%0d",
                         t.token_kind, t.key_char, $signed(t.index_value), t.status,
                         t.segment_count, t.last_of_run);
    endfunction

    function void emit_token(input logic [2:0] kind, input logic [7:0] kc,
                             input logic [31:0] iv, input logic st);
        out_item_t t;
        t.token_kind    = kind;
        t.key_char      = kc;
        t.index_value   = iv;
        t.status        = st;
        t.segment_count = seg_cnt;
        t.last_of_run   = 1'b0;
        item_tokens.push_back(t);
    endfunction

    function void clear_index_state();
        idx_mag  = '0;
        idx_neg  = 1'b0;
        idx_len  = 0;
        idx_star = 1'b0;
        gap_seen = 1'b0;
    endfunction

    function void clear_path_state();
        clear_index_state();
        pstate   = PS_START;
        key_len  = 0;
        bad_path = 1'b0;
        seg_cnt  = '0;
    endfunction

    function void mark_bad();
        bad_path = 1'b1;
        pstate   = PS_FAIL;
    endfunction

    function void count_segment();
        if (seg_cnt != 8'hFF)
            seg_cnt = seg_cnt + 8'd1;
    endfunction

    function void take_key_byte(input logic [7:0] c);
        if (key_len < KEY_KEEP)
        begin
            key_len++;
            emit_token(TK_CHAR, c, '0, 1'b0);
        end
    endfunction

    function void end_key();
        count_segment();
        emit_token(TK_KEYEND, '0, '0, 1'b0);
        key_len  = 0;
        gap_seen = 1'b0;
    endfunction

    // negative magnitude never exceeds 2^31, so a plain negate fits
    function logic [31:0] index_token_value();
        if (idx_neg)
            return 32'd0 - idx_mag;
        return (idx_mag >= MAG_LIMIT) ? POS_MAX : idx_mag;
    endfunction

    function void parse_byte(input logic [7:0] c);
        logic [35:0] grown;
        case (pstate)
            PS_START, PS_DOT:
            begin
                if (c == CH_DOT)
                    pstate = PS_DOT;
                else if (c == CH_LBRACK && pstate == PS_START)
                begin
                    clear_index_state();
                    pstate = PS_BRACKET;
                end
                else if (name_byte(c))
                begin
                    key_len  = 0;
                    gap_seen = 1'b0;
                    take_key_byte(c);
                    pstate = PS_KEY;
                end
                else if (!blank_byte(c))
                    mark_bad();
            end
            PS_KEY:
            begin
                if (c == CH_DOT)
                begin
                    end_key();
                    pstate = PS_DOT;
                end
                else if (c == CH_LBRACK)
                begin
                    end_key();
                    clear_index_state();
                    pstate = PS_BRACKET;
                end
                else if (name_byte(c))
                begin
                    if (gap_seen)
                        mark_bad();
                    else
                        take_key_byte(c);
                end
                else if (blank_byte(c))
                begin
                    if (key_len > 0)
                        gap_seen = 1'b1;
                end
                else
                    mark_bad();
            end
            PS_BRACKET:
            begin
                if (decimal_byte(c))
                begin
                    if (gap_seen)
                        mark_bad();
                    else if (idx_len < IDX_KEEP)
                    begin
                        grown = {4'd0, idx_mag} * 36'd10 + {28'd0, c - CH_ZERO};
                        idx_mag = (grown > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : grown[31:0];
                        idx_len++;
                    end
                end
                else if (c == CH_RBRACK)
                begin
                    if (idx_star && idx_len != 0)
                        mark_bad();
                    else
                    begin
                        count_segment();
                        if (idx_star)
                            emit_token(TK_WILD, '0, '0, 1'b0);
                        else
                            emit_token(TK_INDEX, '0, index_token_value(), 1'b0);
                        clear_index_state();
                        pstate = PS_AFTER;
                    end
                end
                else if (c == CH_STAR)
                    idx_star = 1'b1;
                else if (blank_byte(c))
                begin
                    if (idx_len > 0)
                        gap_seen = 1'b1;
                end
                else if ((c == CH_MINUS || c == CH_PLUS) && idx_len == 0)
                begin
                    idx_neg = (c == CH_MINUS);
                    idx_len = 1;
                end
                else
                    mark_bad();
            end
            PS_AFTER:
            begin
                if (c == CH_DOT)
                    pstate = PS_DOT;
                else if (!blank_byte(c))
                    mark_bad();
            end
            default:
            begin
            end
        endcase
    endfunction

    function void predict_item(input in_item_t it);
        out_item_t t;
        item_tokens.delete();
        if (it.ch != CH_NUL && !bad_path)
            parse_byte(it.ch);
        if (it.last)
        begin
            if (!bad_path)
            begin
                if (pstate == PS_KEY)
                    end_key();
                else if (pstate == PS_BRACKET)
                    mark_bad();
            end
            emit_token(TK_END, '0, '0, bad_path);
            clear_path_state();
        end
        if (item_tokens.size() > 0)
        begin
            t = item_tokens[item_tokens.size() - 1];
            t.last_of_run = 1'b1;
            item_tokens[item_tokens.size() - 1] = t;
        end
        foreach (item_tokens[i])
            expected_tokens.push_back(item_tokens[i]);
    endfunction

    // output side first: a token never leaves on the edge its item enters
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_path_state();
            expected_tokens.delete();
            pending = 0;
        end
        else
        begin
            if (token_valid && !token_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected token: expected none, got %s",
                             $time, token_text(token_item));
                end
                else
                begin
                    oldest = expected_tokens.pop_front();
                    if (token_item !== oldest)
                    begin
                        fail_count++;
                        $display("%0t token mismatch: expected %s, got %s",
                                 $time, token_text(oldest), token_text(token_item));
                    end
                end
            end
            if (char_valid && !char_stall)
                predict_item(char_item);
            pending = expected_tokens.size();
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import cpt_pkg::*;

    // receiver hold-off used to fill the block's internal queue
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 20;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      char_valid  = 1'b0;
    in_item_t  char_item   = '0;
    logic      token_stall = 1'b0;
    logic      char_stall;
    logic      token_valid;
    out_item_t token_item;

    int        fail_count;
    int        tokens_due;

    // idle control set by the stimulus and read by the receiver process
    logic      tx_idle_on = 1'b1;
    logic      rx_idle_on = 1'b1;
    logic      idle_wander = 1'b0;
    logic      hold_req = 1'b0;

    in_item_t   char_items[$];
    logic [7:0] path_text[$];
    string      key_alphabet =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    config_path_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    token_checker token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item),
        .fail_count  (fail_count),
        .pending     (tokens_due)
    );

    // ---------------------------------------------------------------
    // Item building
    // ---------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] c, input logic end_path);
        in_item_t it;
        it.ch   = c;
        it.last = end_path;
        char_items.push_back(it);
    endtask

    task automatic queue_text(input string s, input logic end_path);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], end_path && (i == s.len() - 1));
    endtask

    // optional space or tab run, only where the grammar tolerates blanks
    task automatic add_blanks();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2))
                path_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // mostly short keys; now and then one long enough to hit truncation
    task automatic add_key();
        int len;
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        repeat (len)
            path_text.push_back(key_alphabet[$urandom_range(0, key_alphabet.len() - 1)]);
    endtask

    // wildcard, or optional sign plus digits; long runs reach saturation
    // and the index length cap
    task automatic add_index();
        int ndig;
        path_text.push_back(CH_LBRACK);
        add_blanks();
        if ($urandom_range(0, 4) == 0)
            path_text.push_back(CH_STAR);
        else
        begin
            if ($urandom_range(0, 2) == 0)
                path_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if ($urandom_range(0, 19) == 0)
                ndig = $urandom_range(29, 34);
            else if ($urandom_range(0, 5) == 0)
                ndig = $urandom_range(9, 12);
            else
                ndig = $urandom_range(0, 4);
            repeat (ndig)
                path_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        add_blanks();
        path_text.push_back(CH_RBRACK);
    endtask

    // One path: mostly well formed, the rest noise, a corrupted byte or a
    // truncated tail (often leaving a bracket open).
    task automatic queue_random_path();
        int   shape;
        int   nseg;
        int   pos;
        logic prev_key;
        path_text.delete();
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            repeat ($urandom_range(1, 8))
                path_text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            nseg = $urandom_range(1, 5);
            prev_key = 1'b0;
            add_blanks();
            for (int s = 0; s < nseg; s++)
            begin
                // an index may open the path or follow a key directly
                if ((s == 0 || prev_key) && $urandom_range(0, 2) == 0)
                begin
                    add_index();
                    prev_key = 1'b0;
                end
                else
                begin
                    if (s > 0)
                    begin
                        add_blanks();
                        path_text.push_back(CH_DOT);
                        if ($urandom_range(0, 5) == 0)
                            path_text.push_back(CH_DOT);
                        add_blanks();
                    end
                    add_key();
                    prev_key = 1'b1;
                end
                add_blanks();
            end
            if ($urandom_range(0, 5) == 0)
                path_text.push_back(CH_DOT);
            pos = $urandom_range(0, path_text.size() - 1);
            if (shape >= 8)
                path_text[pos] = 8'($urandom_range(0, 255));
            else if (shape == 7)
                path_text = path_text[0:pos];
            if ($urandom_range(0, 7) == 0)
                path_text.insert(pos, CH_NUL);
        end
        // end either on the final byte or with a bare end marker
        if ($urandom_range(0, 3) == 0)
        begin
            foreach (path_text[i])
                queue_byte(path_text[i], 1'b0);
            queue_byte(CH_NUL, 1'b1);
        end
        else
            foreach (path_text[i])
                queue_byte(path_text[i], i == path_text.size() - 1);
    endtask

    task automatic fill_random(input int target);
        while (char_items.size() < target)
            queue_random_path();
    endtask

    // ---------------------------------------------------------------
    // Sender: entered and left on a falling edge; valid stays up and the
    // payload stays put until the item is taken.
    // ---------------------------------------------------------------
    task automatic send_items();
        in_item_t it;
        int       gap;
        while (char_items.size() > 0)
        begin
            it  = char_items.pop_front();
            gap = tx_idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            char_valid <= 1'b1;
            char_item  <= it;
            do
                @(posedge clk);
            while (char_stall);
            @(negedge clk);
            if (idle_wander && $urandom_range(0, 39) == 0)
                tx_idle_on = !tx_idle_on;
        end
        char_valid <= 1'b0;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Receiver: per token a random stall, or one long hold when asked.
    // ---------------------------------------------------------------
    initial
    begin : receiver
        int   wait_cycles;
        logic hold_done;
        logic rx_flip;
        hold_done = 1'b0;
        rx_flip   = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                wait_cycles = HOLD_CYCLES;
                hold_done   = 1'b1;
            end
            else
                wait_cycles = (rx_idle_on ^ rx_flip) ? $urandom_range(0, 15) : 0;
            if (wait_cycles > 0)
            begin
                token_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            token_stall <= 1'b0;
            do
                @(posedge clk);
            while (!token_valid);
            @(negedge clk);
            if (idle_wander && $urandom_range(0, 29) == 0)
                rx_flip = !rx_flip;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: stray close bracket, blank inside a key, wildcard with a
        // digit, empty signed index, blank inside an index, numeric index then
        // adjacent bracket, wildcard with a bare end marker, top byte value,
        // zero byte alone, trailing dots with a tab, unclosed bracket
        queue_text("]", 1'b1);
        queue_text("a b", 1'b1);
        queue_text("[*1]", 1'b1);
        queue_text("[-]", 1'b1);
        queue_text("[1 2]", 1'b1);
        queue_text("k[7][", 1'b1);
        queue_text("[*]", 1'b0);
        queue_byte(CH_NUL, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(CH_NUL, 1'b0);
        queue_text("x..\t", 1'b1);
        queue_text("[3", 1'b0);
        queue_byte(CH_NUL, 1'b1);
        send_items();

        // back to back on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        fill_random(150);
        send_items();

        // receiver holds off while the sender keeps pushing
        hold_req = 1'b1;
        fill_random(40);
        send_items();

        // sender pauses until every token is out
        wait (tokens_due == 0);
        @(negedge clk);

        // mixed idling with stretches of none
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        idle_wander = 1'b1;
        fill_random(320);
        send_items();

        wait (tokens_due == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && tokens_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
